/* src/bvdw_pkg.sv */
package bvdw_pkg;

    localparam int FRAC_BITS = 16;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int DIST_W     = 24;
    localparam int EPS_W      = 24;
    localparam int R7IN_W     = 40;
    localparam int ROOT_W     = DIST_W + 1;
    localparam int SQ_W       = 2 * ROOT_W;
    localparam int ROOT_REM_W = ROOT_W + 3;
    localparam int MUL_A_W    = 64;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W    = 48;
    localparam int DIV_D_W    = 64;
    localparam int QUO_W      = 32;
    localparam int SUM_W      = 48;
    localparam int MUL_REPS   = 6;

    localparam logic [MUL_A_W-1:0] BIG_CAP  = (MUL_A_W'(1) << 62) - MUL_A_W'(1);
    localparam logic [MUL_A_W-1:0] R7_CAP   = (MUL_A_W'(1) << 56) - MUL_A_W'(1);
    localparam logic [DIST_W-1:0]  DIST_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
        logic [DIST_W-1:0]         min_dist;
        logic [R7IN_W-1:0]         min_dist_pow7;
        logic [EPS_W-1:0]          well_depth;
        logic                      last_pair;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] total_energy;
        logic                    saturated;
    } out_item_t;

    typedef enum logic [2:0] {
        MOP_SQX,
        MOP_SQY,
        MOP_SQZ,
        MOP_EREP,
        MOP_R7,
        MOP_T,
        MOP_MAG
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DEN1,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DEN2,
        ST_ACC,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    far_dist;
        logic    mul_start;
        mul_op_t mul_op;
        logic    root_start;
        logic    div_start;
        logic    div_second;
        logic    zero_pair;
        logic    acc;
        logic    emit;
    } dp_cmd_t;

    typedef struct packed {
        logic far;
        logic den1_zero;
        logic den2_zero;
        logic last;
        logic mul_done;
        logic root_done;
        logic div_done;
        logic mul_busy;
        logic root_busy;
        logic div_busy;
        logic out_busy;
    } dp_stat_t;

endpackage

/* src/bvdw_mul.sv */
module bvdw_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bvdw_pkg::MUL_A_W-1:0]  a,
    input  logic [bvdw_pkg::MUL_B_W-1:0]  b,
    input  logic                          raw,
    input  logic [bvdw_pkg::MUL_A_W-1:0]  cap,
    output logic                          done,
    output logic                          busy,
    output logic [bvdw_pkg::MUL_A_W-1:0]  res
);
    import bvdw_pkg::*;

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic               raw_reg;
    logic [MUL_A_W-1:0] cap_reg;
    logic [63:0]        plo_reg;
    logic [63:0]        phi_reg;
    logic [1:0]         phase_reg;
    logic               done_reg;
    logic [MUL_A_W-1:0] res_reg;
    logic [PROD_W-1:0]  full;
    logic [PROD_W-1:0]  shifted;
    logic [MUL_A_W-1:0] res_next;

    // Two 32x32 partial products, then one combining add with the Q shift and cap (raw mode skips the shift and cap).
    always_comb
    begin
        full    = {phi_reg, 32'd0} + {32'd0, plo_reg};
        shifted = full >> FRAC_BITS;
        if (raw_reg)
        begin
            res_next = full[MUL_A_W-1:0];
        end
        else if (shifted > {{(PROD_W-MUL_A_W){1'b0}}, cap_reg})
        begin
            res_next = cap_reg;
        end
        else
        begin
            res_next = shifted[MUL_A_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == 2'd3);
            if (start)
            begin
                phase_reg <= 2'd1;
            end
            else if (phase_reg != 2'd0)
            begin
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            raw_reg <= raw;
            cap_reg <= cap;
        end
        if (phase_reg == 2'd1)
        begin
            plo_reg <= a_reg[31:0] * b_reg;
        end
        if (phase_reg == 2'd2)
        begin
            phi_reg <= a_reg[63:32] * b_reg;
        end
        if (phase_reg == 2'd3)
        begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign busy = (phase_reg != 2'd0) || done_reg;
    assign res  = res_reg;

endmodule

/* src/bvdw_sqrt.sv */
module bvdw_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bvdw_pkg::SQ_W-1:0]    s,
    output logic                         done,
    output logic                         busy,
    output logic [bvdw_pkg::ROOT_W-1:0]  root
);
    import bvdw_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic [SQ_W-1:0]       s_reg;
    logic [ROOT_REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_REM_W-1:0] rem_sh;
    logic [ROOT_REM_W-1:0] trial;
    logic [ROOT_REM_W-1:0] rem_next;
    logic [ROOT_W-1:0]     root_next;

    // One result bit per cycle, two radicand bits brought down each step.
    always_comb
    begin
        rem_sh = {rem_reg[ROOT_REM_W-3:0], s_reg[SQ_W-1:SQ_W-2]};
        trial  = {1'b0, root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg    <= s;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            s_reg    <= {s_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign busy = busy_reg || done_reg;
    assign root = root_reg;

endmodule

/* src/bvdw_div.sv */
module bvdw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bvdw_pkg::DIV_N_W-1:0]  num,
    input  logic [bvdw_pkg::DIV_D_W-1:0]  den,
    output logic                          done,
    output logic                          busy,
    output logic [bvdw_pkg::QUO_W-1:0]    quo
);
    import bvdw_pkg::*;

    localparam int NSH_W = DIV_N_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QUO_W);

    logic [NSH_W-1:0]   nsh;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [QUO_W-1:0]   low_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W-1:0] rem_sh;

    assign nsh    = {num, {FRAC_BITS{1'b0}}};
    assign rem_sh = {rem_reg[DIV_D_W-2:0], low_reg[QUO_W-1]};

    // The quotient is known to fit QUO_W bits, so the upper numerator bits
    // start out as the partial remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DIV_D_W'(nsh >> QUO_W);
            low_reg <= nsh[QUO_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            if (rem_sh >= den_reg)
            begin
                rem_reg <= rem_sh - den_reg;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign busy = busy_reg || done_reg;
    assign quo  = quo_reg;

endmodule

/* src/bvdw_dp.sv */
module bvdw_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bvdw_pkg::in_item_t   in_data,
    input  bvdw_pkg::dp_cmd_t    cmd,
    output bvdw_pkg::dp_stat_t   stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output bvdw_pkg::out_item_t  out_data
);
    import bvdw_pkg::*;

    localparam logic [QUO_W:0] TWO_Q = (QUO_W+1)'(2) << FRAC_BITS;
    localparam logic signed [63:0] SUM_MAX = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SUM_MIN = -(64'sd1 <<< (SUM_W - 1));

    logic [DIFF_W-1:0]       dx_reg, dy_reg, dz_reg;
    logic [DIST_W-1:0]       rmin_reg;
    logic [R7IN_W-1:0]       r7in_reg;
    logic [EPS_W-1:0]        eps_reg;
    logic                    last_reg;
    logic [SQ_W-1:0]         ssq_reg;
    logic [DIST_W-1:0]       r_reg;
    logic [QUO_W-1:0]        erep_reg;
    logic [MUL_A_W-1:0]      erep7_reg;
    logic [MUL_A_W-1:0]      r7_reg;
    logic                    eneg_reg;
    logic [QUO_W-1:0]        emag_reg;
    logic [MUL_A_W-1:0]      t_reg;
    logic [MUL_A_W-1:0]      mag_reg;
    logic                    zero_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    clip_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;

    logic [DIFF_W-1:0]   ddx, ddy, ddz;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_raw;
    logic [MUL_A_W-1:0]  mul_cap;
    logic [MUL_A_W-1:0]  mul_res;
    logic                mul_done, mul_busy;
    logic [ROOT_W-1:0]   root;
    logic                root_done, root_busy;
    logic [DIST_W-1:0]   r_new;
    logic [DIV_N_W-1:0]  div_num;
    logic [DIV_D_W-1:0]  div_den;
    logic [QUO_W-1:0]    quo;
    logic                div_done, div_busy;
    logic [QUO_W:0]      eattr;
    logic signed [63:0]  pair;
    logic signed [63:0]  sum_raw;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] p,
                                                   input logic signed [COORD_W-1:0] q);
        logic [DIFF_W-1:0] d;
        d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
        return d[DIFF_W-1] ? (~d + 1'b1) : d;
    endfunction

    assign ddx = abs_diff(in_data.ax, in_data.bx);
    assign ddy = abs_diff(in_data.ay, in_data.by);
    assign ddz = abs_diff(in_data.az, in_data.bz);

    always_comb
    begin
        mul_raw = 1'b0;
        mul_cap = BIG_CAP;
        unique case (cmd.mul_op)
            MOP_SQX:
            begin
                mul_a   = MUL_A_W'(dx_reg[DIST_W-1:0]);
                mul_b   = MUL_B_W'(dx_reg[DIST_W-1:0]);
                mul_raw = 1'b1;
            end
            MOP_SQY:
            begin
                mul_a   = MUL_A_W'(dy_reg[DIST_W-1:0]);
                mul_b   = MUL_B_W'(dy_reg[DIST_W-1:0]);
                mul_raw = 1'b1;
            end
            MOP_SQZ:
            begin
                mul_a   = MUL_A_W'(dz_reg[DIST_W-1:0]);
                mul_b   = MUL_B_W'(dz_reg[DIST_W-1:0]);
                mul_raw = 1'b1;
            end
            MOP_EREP:
            begin
                mul_a = erep7_reg;
                mul_b = erep_reg;
            end
            MOP_R7:
            begin
                mul_a   = r7_reg;
                mul_b   = MUL_B_W'(r_reg);
                mul_cap = R7_CAP;
            end
            MOP_T:
            begin
                mul_a = erep7_reg;
                mul_b = MUL_B_W'(eps_reg);
            end
            MOP_MAG:
            begin
                mul_a = t_reg;
                mul_b = emag_reg;
            end
            default:
            begin
                mul_a = t_reg;
                mul_b = emag_reg;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.div_second)
        begin
            div_num = DIV_N_W'(r7in_reg) * DIV_N_W'(112);
            div_den = r7_reg * DIV_D_W'(100) + DIV_D_W'(r7in_reg) * DIV_D_W'(12);
        end
        else
        begin
            div_num = DIV_N_W'(rmin_reg) * DIV_N_W'(107);
            div_den = DIV_D_W'(r_reg) * DIV_D_W'(100) + DIV_D_W'(rmin_reg) * DIV_D_W'(7);
        end
    end

    bvdw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .raw   (mul_raw),
        .cap   (mul_cap),
        .done  (mul_done),
        .busy  (mul_busy),
        .res   (mul_res)
    );

    bvdw_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .s     (ssq_reg),
        .done  (root_done),
        .busy  (root_busy),
        .root  (root)
    );

    bvdw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign r_new = root[ROOT_W-1] ? DIST_MAX : root[DIST_W-1:0];
    assign eattr = {1'b0, quo} - TWO_Q;

    always_comb
    begin
        if (zero_reg)
        begin
            pair = 64'sd0;
        end
        else if (eneg_reg)
        begin
            pair = -$signed(mag_reg);
        end
        else
        begin
            pair = $signed(mag_reg);
        end
        sum_raw = 64'(sum_reg) + pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                zero_reg <= 1'b0;
            end
            else if (cmd.zero_pair)
            begin
                zero_reg <= 1'b1;
            end

            if (cmd.acc)
            begin
                if (sum_raw > SUM_MAX)
                begin
                    sum_reg  <= SUM_MAX[SUM_W-1:0];
                    clip_reg <= 1'b1;
                end
                else if (sum_raw < SUM_MIN)
                begin
                    sum_reg  <= SUM_MIN[SUM_W-1:0];
                    clip_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_raw[SUM_W-1:0];
                end
            end
            else if (cmd.emit)
            begin
                sum_reg  <= '0;
                clip_reg <= 1'b0;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg   <= ddx;
            dy_reg   <= ddy;
            dz_reg   <= ddz;
            rmin_reg <= in_data.min_dist;
            r7in_reg <= in_data.min_dist_pow7;
            eps_reg  <= in_data.well_depth;
            last_reg <= in_data.last_pair;
            ssq_reg  <= '0;
        end
        if (cmd.far_dist)
        begin
            r_reg  <= DIST_MAX;
            r7_reg <= MUL_A_W'(DIST_MAX);
        end
        if (root_done)
        begin
            r_reg  <= r_new;
            r7_reg <= MUL_A_W'(r_new);
        end
        if (mul_done)
        begin
            case (cmd.mul_op) inside
                MOP_SQX, MOP_SQY, MOP_SQZ: ssq_reg   <= ssq_reg + mul_res[SQ_W-1:0];
                MOP_EREP:                  erep7_reg <= mul_res;
                MOP_R7:                    r7_reg    <= mul_res;
                MOP_T:                     t_reg     <= mul_res;
                default:                   mag_reg   <= mul_res;
            endcase
        end
        if (div_done)
        begin
            if (cmd.div_second)
            begin
                eneg_reg <= eattr[QUO_W];
                emag_reg <= eattr[QUO_W] ? QUO_W'(~eattr + 1'b1) : eattr[QUO_W-1:0];
            end
            else
            begin
                erep_reg  <= quo;
                erep7_reg <= MUL_A_W'(quo);
            end
        end
        if (cmd.emit)
        begin
            out_reg.total_energy <= sum_reg;
            out_reg.saturated    <= clip_reg;
        end
    end

    always_comb
    begin
        stat.far       = (dx_reg[DIFF_W-1:DIST_W] != '0) || (dy_reg[DIFF_W-1:DIST_W] != '0)
                         || (dz_reg[DIFF_W-1:DIST_W] != '0);
        stat.den1_zero = (r_reg == '0) && (rmin_reg == '0);
        stat.den2_zero = (r7_reg == '0) && (r7in_reg == '0);
        stat.last      = last_reg;
        stat.mul_done  = mul_done;
        stat.root_done = root_done;
        stat.div_done  = div_done;
        stat.mul_busy  = mul_busy;
        stat.root_busy = root_busy;
        stat.div_busy  = div_busy;
        stat.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* src/bvdw_ctrl.sv */
module bvdw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output bvdw_pkg::dp_cmd_t   cmd,
    input  bvdw_pkg::dp_stat_t  stat
);
    import bvdw_pkg::*;

    localparam int REP_W = $clog2(MUL_REPS);

    ctrl_state_t      state_reg, state_next;
    mul_op_t          mop_reg, mop_next;
    logic [REP_W-1:0] rep_reg, rep_next;
    logic             dsel_reg, dsel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mop_reg   <= MOP_SQX;
            rep_reg   <= '0;
            dsel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mop_reg   <= mop_next;
            rep_reg   <= rep_next;
            dsel_reg  <= dsel_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mop_next       = mop_reg;
        rep_next       = rep_reg;
        dsel_next      = dsel_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_op     = mop_reg;
        cmd.div_second = dsel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                if (stat.far)
                begin
                    cmd.far_dist = 1'b1;
                    state_next   = ST_DEN1;
                end
                else
                begin
                    mop_next   = MOP_SQX;
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (stat.mul_done)
                begin
                    state_next = ST_MUL_GO;
                    case (mop_reg)
                        MOP_SQX: mop_next = MOP_SQY;
                        MOP_SQY: mop_next = MOP_SQZ;
                        MOP_SQZ: state_next = ST_ROOT_GO;
                        MOP_EREP:
                        begin
                            if (rep_reg == REP_W'(MUL_REPS - 1))
                            begin
                                rep_next = '0;
                                mop_next = MOP_R7;
                            end
                            else
                            begin
                                rep_next = rep_reg + 1'b1;
                            end
                        end
                        MOP_R7:
                        begin
                            if (rep_reg == REP_W'(MUL_REPS - 1))
                            begin
                                state_next = ST_DEN2;
                            end
                            else
                            begin
                                rep_next = rep_reg + 1'b1;
                            end
                        end
                        MOP_T:   mop_next = MOP_MAG;
                        default: state_next = ST_ACC;
                    endcase
                end
            end
            ST_ROOT_GO:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (stat.root_done)
                begin
                    state_next = ST_DEN1;
                end
            end
            ST_DEN1:
            begin
                if (stat.den1_zero)
                begin
                    cmd.zero_pair = 1'b1;
                    state_next    = ST_ACC;
                end
                else
                begin
                    dsel_next  = 1'b0;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MUL_GO;
                    rep_next   = '0;
                    mop_next   = dsel_reg ? MOP_T : MOP_EREP;
                end
            end
            ST_DEN2:
            begin
                if (stat.den2_zero)
                begin
                    cmd.zero_pair = 1'b1;
                    state_next    = ST_ACC;
                end
                else
                begin
                    dsel_next  = 1'b1;
                    state_next = ST_DIV_GO;
                end
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = stat.last ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/buffered_vdw_pair_energy_sum_top.sv */
// Channel | Handshake            | Payload               | Moves
// input   | in_valid / in_ready  | in_data (in_item_t)   | one atom pair
// output  | out_valid / out_ready| out_data (out_item_t) | energy total and clip flag
//
// One item at a time; an item runs from acceptance to the accumulate step, taking a
// shorter path when the atoms are far apart, when the first denominator is zero and when
// the second is. A last pair then waits in an output step until the output can take its total.
// The work is set by the shared two-pass multiplier (up to 17 products), the
// one-bit-per-cycle root unit and two 32-step divisions.
// rst_n clears the running sum, the clip flag and the output valid flag at once.
// A waiting result does not block the next item; only a second last pair holds
// until the first result is taken.
module buffered_vdw_pair_energy_sum_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bvdw_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bvdw_pkg::out_item_t  out_data
);
    import bvdw_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bvdw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bvdw_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // The arithmetic units must be idle whenever a new item can enter.
    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stat.mul_busy && !stat.root_busy && !stat.div_busy)
        else $error("arithmetic unit busy while accepting an item");

    a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul_start, cmd.root_start, cmd.div_start, cmd.load}))
        else $error("more than one unit started at once");

    a_rise_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit))
        else $error("result appeared without an emit");

endmodule
